// File: rtl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared widths, register indexes, sideband type and rotation constants for
// the UV sphere vertex generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

	localparam int CNT_W     = 11;
	localparam int RAD_W     = 16;
	localparam int POS_W     = 17;
	localparam int UNIT_W    = 16;
	localparam int TEX_W     = 17;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLICES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STACKS = 2'd2;

	localparam logic [RAD_W-1:0] RADIUS_RST = 16'd256;
	localparam logic [CNT_W-1:0] SLICES_RST = 11'd16;
	localparam logic [CNT_W-1:0] STACKS_RST = 11'd16;
	localparam logic [CNT_W-1:0] MIN_SLICES = 11'd3;
	localparam logic [CNT_W-1:0] MIN_STACKS = 11'd2;

	localparam int PHASE_W   = 32;
	localparam int QUOT_W    = PHASE_W + 1;
	localparam int DIV_CELLS = CNT_W + PHASE_W;

	localparam int CORDIC_STEPS = 24;
	localparam int CORDIC_W     = 33;
	localparam logic signed [CORDIC_W-1:0] CORDIC_K = 33'sd652032874;

	localparam logic signed [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
		32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
		32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
		32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
		32'sd652,       32'sd326,       32'sd163,       32'sd81
	};

	typedef struct packed {
		logic             valid;
		logic             err;
		logic             top;
		logic             bot;
		logic [TEX_W-1:0] tex_u;
		logic [TEX_W-1:0] tex_v;
	} side_t;

endpackage

// File: rtl/uvs_in_if.sv
// ----------------------------------------------------------------------------
// uvs_in_if
// Grid point channel: ring and slice index with valid/ready.
// ----------------------------------------------------------------------------
interface uvs_in_if;
	logic                        valid;
	logic                        ready;
	logic [uvs_pkg::CNT_W-1:0]   ring_index;
	logic [uvs_pkg::CNT_W-1:0]   slice_index;

	modport source(output valid, ring_index, slice_index, input ready);
	modport sink(input valid, ring_index, slice_index, output ready);
endinterface

// File: rtl/uvs_out_if.sv
// ----------------------------------------------------------------------------
// uvs_out_if
// Vertex channel: position, normal, tangent, texture coordinate, error flag.
// ----------------------------------------------------------------------------
interface uvs_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [uvs_pkg::POS_W-1:0]   pos_x;
	logic signed [uvs_pkg::POS_W-1:0]   pos_y;
	logic signed [uvs_pkg::POS_W-1:0]   pos_z;
	logic signed [uvs_pkg::UNIT_W-1:0]  normal_x;
	logic signed [uvs_pkg::UNIT_W-1:0]  normal_y;
	logic signed [uvs_pkg::UNIT_W-1:0]  normal_z;
	logic signed [uvs_pkg::UNIT_W-1:0]  tangent_x;
	logic                               tangent_y;
	logic signed [uvs_pkg::UNIT_W-1:0]  tangent_z;
	logic [uvs_pkg::TEX_W-1:0]          tex_u;
	logic [uvs_pkg::TEX_W-1:0]          tex_v;
	logic                               index_error;

	modport source(output valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
		tangent_x, tangent_y, tangent_z, tex_u, tex_v, index_error, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
		tangent_x, tangent_y, tangent_z, tex_u, tex_v, index_error, output ready);
endinterface

// File: rtl/uvs_div_cell.sv
// ----------------------------------------------------------------------------
// uvs_div_cell
// One restoring division step: brings in one dividend bit, emits one
// quotient bit, passes remainder and partial quotient to the next cell.
// ----------------------------------------------------------------------------
module uvs_div_cell #(
	parameter int POS = 0
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [uvs_pkg::CNT_W-1:0]   d,
	input  logic [uvs_pkg::CNT_W-1:0]   n_in,
	input  logic [uvs_pkg::CNT_W-1:0]   rem_in,
	input  logic [uvs_pkg::QUOT_W-1:0]  q_in,
	output logic [uvs_pkg::CNT_W-1:0]   n_q,
	output logic [uvs_pkg::CNT_W-1:0]   rem_q,
	output logic [uvs_pkg::QUOT_W-1:0]  q_q
);
	logic                       b;
	logic [uvs_pkg::CNT_W:0]    trial;
	logic [uvs_pkg::CNT_W:0]    diff;
	logic                       ge;

	if (POS < uvs_pkg::CNT_W) begin : g_lead
		assign b = n_in[uvs_pkg::CNT_W-1-POS];
	end else begin : g_tail
		assign b = 1'b0;
	end

	assign trial = {rem_in, b};
	assign diff  = trial - {1'b0, d};
	assign ge    = trial >= {1'b0, d};

	always_ff @(posedge clk) begin
		if (en) begin
			n_q   <= n_in;
			rem_q <= ge ? diff[uvs_pkg::CNT_W-1:0] : trial[uvs_pkg::CNT_W-1:0];
			q_q   <= {q_in[uvs_pkg::QUOT_W-2:0], ge};
		end
	end
endmodule

// File: rtl/uvs_cordic_cell.sv
// ----------------------------------------------------------------------------
// uvs_cordic_cell
// One rotation step of the sine/cosine chain, registered.
// ----------------------------------------------------------------------------
module uvs_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [uvs_pkg::CORDIC_W-1:0]  x_in,
	input  logic signed [uvs_pkg::CORDIC_W-1:0]  y_in,
	input  logic signed [uvs_pkg::CORDIC_W-1:0]  z_in,
	input  logic [1:0]                           quad_in,
	output logic signed [uvs_pkg::CORDIC_W-1:0]  x_q,
	output logic signed [uvs_pkg::CORDIC_W-1:0]  y_q,
	output logic signed [uvs_pkg::CORDIC_W-1:0]  z_q,
	output logic [1:0]                           quad_q
);
	logic signed [uvs_pkg::CORDIC_W-1:0] dx;
	logic signed [uvs_pkg::CORDIC_W-1:0] dy;
	logic signed [uvs_pkg::CORDIC_W-1:0] at;

	assign dx = y_in >>> STEP;
	assign dy = x_in >>> STEP;
	assign at = uvs_pkg::CORDIC_W'(uvs_pkg::ATAN_TAB[STEP]);

	always_ff @(posedge clk) begin
		if (en) begin
			quad_q <= quad_in;
			if (!z_in[uvs_pkg::CORDIC_W-1]) begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				z_q <= z_in - at;
			end else begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				z_q <= z_in + at;
			end
		end
	end
endmodule

// File: rtl/uv_sphere_vertex_generator_core.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_core
// Grid point (ring, slice) to sphere vertex: two divider cell chains make the
// angle phases, two rotation cell chains make sine and cosine, then products,
// rounding and pole/error selection.
//
//   channel   dir   width         transfer
//   in_item   in    2 x 11        valid & ready
//   out_item  out   see interface valid & ready
//   cfg       in    2 + 16        cfg_we
//
// One item per cycle while the output is taken; stages: 1 input, 43 divider cells,
// 24 rotation cells, 4 arithmetic stages, 1 output register.
// The whole pipeline advances together; it holds while the output register
// is full and not taken. Reset clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_core #(
	parameter int MAX_COUNT = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [uvs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [uvs_pkg::CFG_DAT_W-1:0]      cfg_data,
	uvs_in_if.sink                             in_item,
	uvs_out_if.source                          out_item
);
	localparam int NC = uvs_pkg::DIV_CELLS;
	localparam int NR = uvs_pkg::CORDIC_STEPS;
	localparam int CW = uvs_pkg::CNT_W;
	localparam int RW = uvs_pkg::CORDIC_W;
	localparam int QW = uvs_pkg::QUOT_W;

	function automatic logic [uvs_pkg::TEX_W-1:0] tex_round(input logic [QW-1:0] q);
		logic [QW-15:0] s;
		s = {1'b0, q[QW-1:15]} + (QW-14)'(1);
		return s[uvs_pkg::TEX_W:1];
	endfunction

	function automatic logic signed [uvs_pkg::UNIT_W-1:0] to_q14(input logic signed [31:0] v);
		logic signed [32:0] t;
		t = (33'(v) + 33'sd32768) >>> 16;
		if (t > 33'sd16384) t = 33'sd16384;
		if (t < -33'sd16384) t = -33'sd16384;
		return uvs_pkg::UNIT_W'(t);
	endfunction

	function automatic logic signed [uvs_pkg::POS_W-1:0] to_pos(input logic signed [48:0] r);
		logic signed [49:0] t;
		t = (50'(r) + 50'sd536870912) >>> 30;
		if (t > 50'sd65535) t = 50'sd65535;
		if (t < -50'sd65535) t = -50'sd65535;
		return uvs_pkg::POS_W'(t);
	endfunction

	// configuration
	logic [uvs_pkg::RAD_W-1:0] radius_q;
	logic [CW-1:0]             slice_count_q;
	logic [CW-1:0]             stack_count_q;
	logic [CW-1:0]             s_eff;
	logic [CW-1:0]             t_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q      <= uvs_pkg::RADIUS_RST;
			slice_count_q <= uvs_pkg::SLICES_RST;
			stack_count_q <= uvs_pkg::STACKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				uvs_pkg::REG_RADIUS: radius_q      <= cfg_data;
				uvs_pkg::REG_SLICES: slice_count_q <= cfg_data[CW-1:0];
				uvs_pkg::REG_STACKS: stack_count_q <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		s_eff = slice_count_q;
		if (slice_count_q < uvs_pkg::MIN_SLICES) s_eff = uvs_pkg::MIN_SLICES;
		else if (32'(slice_count_q) > 32'(MAX_COUNT)) s_eff = CW'(MAX_COUNT);
		t_eff = stack_count_q;
		if (stack_count_q < uvs_pkg::MIN_STACKS) t_eff = uvs_pkg::MIN_STACKS;
		else if (32'(stack_count_q) > 32'(MAX_COUNT)) t_eff = CW'(MAX_COUNT);
	end

	// pipeline control
	logic out_valid_q;
	logic adv;

	assign adv           = !out_valid_q || out_item.ready;
	assign in_item.ready = adv;

	// input stage
	logic          v_s1;
	logic [CW-1:0] ring_s1;
	logic [CW-1:0] slice_s1;
	uvs_pkg::side_t side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_item.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ring_s1  <= in_item.ring_index;
			slice_s1 <= in_item.slice_index;
		end
	end

	always_comb begin
		side_s1       = '0;
		side_s1.valid = v_s1;
		side_s1.top   = ring_s1 == '0;
		side_s1.bot   = ring_s1 == t_eff;
		side_s1.err   = (ring_s1 > t_eff) ||
			(ring_s1 != '0 && ring_s1 != t_eff && slice_s1 > s_eff);
	end

	// divider cell chains
	logic [CW-1:0] thn [NC];
	logic [CW-1:0] thr [NC];
	logic [QW-1:0] thq [NC];
	logic [CW-1:0] phn [NC];
	logic [CW-1:0] phr [NC];
	logic [QW-1:0] phq [NC];
	uvs_pkg::side_t sd [NC];

	for (genvar j = 0; j < NC; j++) begin : g_div
		logic [CW-1:0] tn_i, tr_i, pn_i, pr_i;
		logic [QW-1:0] tq_i, pq_i;
		if (j == 0) begin : g_first
			assign tn_i = slice_s1;
			assign tr_i = '0;
			assign tq_i = '0;
			assign pn_i = ring_s1;
			assign pr_i = '0;
			assign pq_i = '0;
		end else begin : g_next
			assign tn_i = thn[j-1];
			assign tr_i = thr[j-1];
			assign tq_i = thq[j-1];
			assign pn_i = phn[j-1];
			assign pr_i = phr[j-1];
			assign pq_i = phq[j-1];
		end
		uvs_div_cell #(.POS(j)) u_th (
			.clk(clk), .en(adv), .d(s_eff), .n_in(tn_i), .rem_in(tr_i), .q_in(tq_i),
			.n_q(thn[j]), .rem_q(thr[j]), .q_q(thq[j])
		);
		uvs_div_cell #(.POS(j)) u_ph (
			.clk(clk), .en(adv), .d(t_eff), .n_in(pn_i), .rem_in(pr_i), .q_in(pq_i),
			.n_q(phn[j]), .rem_q(phr[j]), .q_q(phq[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sd <= '{default: '0};
		end else if (adv) begin
			sd[0] <= side_s1;
			for (int k = 1; k < NC; k++) sd[k] <= sd[k-1];
		end
	end

	// rotation cell chains
	logic [31:0]          th_phase;
	logic [31:0]          ph_phase;
	uvs_pkg::side_t       side_div;
	logic signed [RW-1:0] tx_c [NR];
	logic signed [RW-1:0] ty_c [NR];
	logic signed [RW-1:0] tz_c [NR];
	logic [1:0]           tqd_c [NR];
	logic signed [RW-1:0] px_c [NR];
	logic signed [RW-1:0] py_c [NR];
	logic signed [RW-1:0] pz_c [NR];
	logic [1:0]           pqd_c [NR];
	uvs_pkg::side_t       sc [NR];

	assign th_phase = thq[NC-1][31:0];
	assign ph_phase = phq[NC-1][QW-1:1];

	always_comb begin
		side_div       = sd[NC-1];
		side_div.tex_u = tex_round(thq[NC-1]);
		side_div.tex_v = tex_round(phq[NC-1]);
	end

	for (genvar i = 0; i < NR; i++) begin : g_rot
		logic signed [RW-1:0] tx_i, ty_i, tz_i, px_i, py_i, pz_i;
		logic [1:0]           tqd_i, pqd_i;
		if (i == 0) begin : g_first
			assign tx_i  = uvs_pkg::CORDIC_K;
			assign ty_i  = '0;
			assign tz_i  = {3'b000, th_phase[29:0]};
			assign tqd_i = th_phase[31:30];
			assign px_i  = uvs_pkg::CORDIC_K;
			assign py_i  = '0;
			assign pz_i  = {3'b000, ph_phase[29:0]};
			assign pqd_i = ph_phase[31:30];
		end else begin : g_next
			assign tx_i  = tx_c[i-1];
			assign ty_i  = ty_c[i-1];
			assign tz_i  = tz_c[i-1];
			assign tqd_i = tqd_c[i-1];
			assign px_i  = px_c[i-1];
			assign py_i  = py_c[i-1];
			assign pz_i  = pz_c[i-1];
			assign pqd_i = pqd_c[i-1];
		end
		uvs_cordic_cell #(.STEP(i)) u_th (
			.clk(clk), .en(adv), .x_in(tx_i), .y_in(ty_i), .z_in(tz_i), .quad_in(tqd_i),
			.x_q(tx_c[i]), .y_q(ty_c[i]), .z_q(tz_c[i]), .quad_q(tqd_c[i])
		);
		uvs_cordic_cell #(.STEP(i)) u_ph (
			.clk(clk), .en(adv), .x_in(px_i), .y_in(py_i), .z_in(pz_i), .quad_in(pqd_i),
			.x_q(px_c[i]), .y_q(py_c[i]), .z_q(pz_c[i]), .quad_q(pqd_c[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc <= '{default: '0};
		end else if (adv) begin
			sc[0] <= side_div;
			for (int k = 1; k < NR; k++) sc[k] <= sc[k-1];
		end
	end

	// quadrant fold
	logic signed [31:0] st_c, ct_c, sp_c, cp_c;

	always_comb begin
		case (tqd_c[NR-1])
			2'd0: begin ct_c = 32'(tx_c[NR-1]);  st_c = 32'(ty_c[NR-1]);  end
			2'd1: begin ct_c = 32'(-ty_c[NR-1]); st_c = 32'(tx_c[NR-1]);  end
			2'd2: begin ct_c = 32'(-tx_c[NR-1]); st_c = 32'(-ty_c[NR-1]); end
			default: begin ct_c = 32'(ty_c[NR-1]); st_c = 32'(-tx_c[NR-1]); end
		endcase
		case (pqd_c[NR-1])
			2'd0: begin cp_c = 32'(px_c[NR-1]);  sp_c = 32'(py_c[NR-1]);  end
			2'd1: begin cp_c = 32'(-py_c[NR-1]); sp_c = 32'(px_c[NR-1]);  end
			2'd2: begin cp_c = 32'(-px_c[NR-1]); sp_c = 32'(-py_c[NR-1]); end
			default: begin cp_c = 32'(py_c[NR-1]); sp_c = 32'(-px_c[NR-1]); end
		endcase
	end

	// arithmetic stages
	uvs_pkg::side_t     sb_s2, sb_s3, sb_s4, sb_s5;
	logic signed [31:0] sp_s2, cp_s2, st_s2, ct_s2;
	logic signed [63:0] pux_s3, puz_s3;
	logic signed [31:0] cp_s3, st_s3, ct_s3;
	logic signed [31:0] ux_s4, uz_s4, cp_s4, st_s4, ct_s4;
	logic signed [63:0] ux_r, uz_r;
	logic signed [48:0] rx_s5, ry_s5, rz_s5;
	logic signed [uvs_pkg::UNIT_W-1:0] nx_s5, ny_s5, nz_s5, tgx_s5, tgz_s5;

	assign ux_r = (pux_s3 + 64'sd536870912) >>> 30;
	assign uz_r = (puz_s3 + 64'sd536870912) >>> 30;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_s2 <= '0;
			sb_s3 <= '0;
			sb_s4 <= '0;
			sb_s5 <= '0;
		end else if (adv) begin
			sb_s2 <= sc[NR-1];
			sb_s3 <= sb_s2;
			sb_s4 <= sb_s3;
			sb_s5 <= sb_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sp_s2  <= sp_c;
			cp_s2  <= cp_c;
			st_s2  <= st_c;
			ct_s2  <= ct_c;
			pux_s3 <= sp_s2 * ct_s2;
			puz_s3 <= sp_s2 * st_s2;
			cp_s3  <= cp_s2;
			st_s3  <= st_s2;
			ct_s3  <= ct_s2;
			ux_s4  <= 32'(ux_r);
			uz_s4  <= 32'(uz_r);
			cp_s4  <= cp_s3;
			st_s4  <= st_s3;
			ct_s4  <= ct_s3;
			rx_s5  <= $signed({1'b0, radius_q}) * ux_s4;
			ry_s5  <= $signed({1'b0, radius_q}) * cp_s4;
			rz_s5  <= $signed({1'b0, radius_q}) * uz_s4;
			nx_s5  <= to_q14(ux_s4);
			ny_s5  <= to_q14(cp_s4);
			nz_s5  <= to_q14(uz_s4);
			tgx_s5 <= to_q14(-st_s4);
			tgz_s5 <= to_q14(ct_s4);
		end
	end

	// output register
	logic signed [uvs_pkg::POS_W-1:0]  px_q, py_q, pz_q;
	logic signed [uvs_pkg::UNIT_W-1:0] nx_q, ny_q, nz_q, tgx_q, tgz_q;
	logic [uvs_pkg::TEX_W-1:0]         tu_q, tv_q;
	logic                              err_q;
	logic signed [uvs_pkg::POS_W-1:0]  rad_p;

	assign rad_p = $signed({1'b0, radius_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= sb_s5.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_q  <= '0;
			py_q  <= '0;
			pz_q  <= '0;
			nx_q  <= '0;
			ny_q  <= '0;
			nz_q  <= '0;
			tgx_q <= '0;
			tgz_q <= '0;
			tu_q  <= '0;
			tv_q  <= '0;
			err_q <= 1'b0;
			if (sb_s5.err) begin
				err_q <= 1'b1;
			end else if (sb_s5.top) begin
				py_q  <= rad_p;
				ny_q  <= 16'sd16384;
				tgx_q <= 16'sd16384;
			end else if (sb_s5.bot) begin
				py_q  <= -rad_p;
				ny_q  <= -16'sd16384;
				tgx_q <= 16'sd16384;
				tv_q  <= 17'd65536;
			end else begin
				px_q  <= to_pos(rx_s5);
				py_q  <= to_pos(ry_s5);
				pz_q  <= to_pos(rz_s5);
				nx_q  <= nx_s5;
				ny_q  <= ny_s5;
				nz_q  <= nz_s5;
				tgx_q <= tgx_s5;
				tgz_q <= tgz_s5;
				tu_q  <= sb_s5.tex_u;
				tv_q  <= sb_s5.tex_v;
			end
		end
	end

	assign out_item.valid       = out_valid_q;
	assign out_item.pos_x       = px_q;
	assign out_item.pos_y       = py_q;
	assign out_item.pos_z       = pz_q;
	assign out_item.normal_x    = nx_q;
	assign out_item.normal_y    = ny_q;
	assign out_item.normal_z    = nz_q;
	assign out_item.tangent_x   = tgx_q;
	assign out_item.tangent_y   = 1'b0;
	assign out_item.tangent_z   = tgz_q;
	assign out_item.tex_u       = tu_q;
	assign out_item.tex_v       = tv_q;
	assign out_item.index_error = err_q;
endmodule

// File: sim/uvs_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UV sphere vertex generator: directed poles,
// extremes and index errors, then random grid points over several register
// settings and sender/receiver idle phases; each vertex is predicted from a
// bit-true CORDIC model and checked in order.
// ----------------------------------------------------------------------------
module tb;

	localparam int LATENCY   = 73;
	localparam int WD_LIMIT  = 20000;
	localparam int PW        = uvs_pkg::POS_W;
	localparam int UW        = uvs_pkg::UNIT_W;
	localparam int TW        = uvs_pkg::TEX_W;

	typedef struct packed {
		logic signed [PW-1:0] px, py, pz;
		logic signed [UW-1:0] nx, ny, nz, tx;
		logic                 ty;
		logic signed [UW-1:0] tz;
		logic [TW-1:0]        tu, tv;
		logic                 err;
	} vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [uvs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [uvs_pkg::CFG_DAT_W-1:0] cfg_data = '0;

	uvs_in_if  in_item();
	uvs_out_if out_item();

	uv_sphere_vertex_generator_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_item(in_item), .out_item(out_item)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	int unsigned m_radius, m_slices, m_stacks;
	vertex_t vertex_q[$];
	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int watchdog = 0;

	initial begin
		in_item.valid = 1'b0;
		in_item.ring_index = '0;
		in_item.slice_index = '0;
		out_item.ready = 1'b0;
	end

	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint sat(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	task automatic cordic_sincos(input logic [31:0] phase, output longint s, output longint c);
		longint x, y, z, dx, dy;
		x = uvs_pkg::CORDIC_K;
		y = 0;
		z = phase[29:0];
		for (int i = 0; i < uvs_pkg::CORDIC_STEPS; i++) begin
			dx = fshr(y, i);
			dy = fshr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= uvs_pkg::ATAN_TAB[i];
			end else begin
				x += dx; y -= dy; z += uvs_pkg::ATAN_TAB[i];
			end
		end
		case (phase[31:30])
			2'd0: begin c = x;  s = y;  end
			2'd1: begin c = -y; s = x;  end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	function automatic longint q14(longint v);
		return sat(fshr(v + (64'sd1 <<< 15), 16), 16384);
	endfunction

	function automatic longint posq(longint u);
		return sat(fshr(longint'(m_radius) * u + (64'sd1 <<< 29), 30), 65535);
	endfunction

	function automatic longint texq(longint idx, longint cnt);
		return (idx * 131072 + cnt) / (2 * cnt);
	endfunction

	task automatic predict_vertex(input int unsigned ring, input int unsigned slice,
			output vertex_t v);
		int unsigned s_eff, t_eff;
		longint sp, cp, st, ct, ux, uz;
		logic [31:0] th, ph;
		longint thl;
		s_eff = m_slices < 3 ? 3 : (m_slices > 1024 ? 1024 : m_slices);
		t_eff = m_stacks < 2 ? 2 : (m_stacks > 1024 ? 1024 : m_stacks);
		v = '0;
		if (ring > t_eff || (ring != 0 && ring != t_eff && slice > s_eff)) begin
			v.err = 1'b1;
		end else if (ring == 0) begin
			v.py = PW'(m_radius); v.ny = 16384; v.tx = 16384;
		end else if (ring == t_eff) begin
			v.py = PW'(-longint'(m_radius)); v.ny = -16384; v.tx = 16384; v.tv = 65536;
		end else begin
			thl = (longint'(slice) <<< 32) / s_eff;
			th = thl[31:0];
			ph = 32'((longint'(ring) <<< 31) / t_eff);
			cordic_sincos(ph, sp, cp);
			cordic_sincos(th, st, ct);
			ux = fshr(sp * ct + (64'sd1 <<< 29), 30);
			uz = fshr(sp * st + (64'sd1 <<< 29), 30);
			v.px = PW'(posq(ux)); v.py = PW'(posq(cp)); v.pz = PW'(posq(uz));
			v.nx = UW'(q14(ux)); v.ny = UW'(q14(cp)); v.nz = UW'(q14(uz));
			v.tx = UW'(q14(-st)); v.tz = UW'(q14(ct));
			v.tu = TW'(texq(slice, s_eff));
			v.tv = TW'(texq(ring, t_eff));
		end
	endtask

	task automatic write_reg(input logic [uvs_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[uvs_pkg::CFG_DAT_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			uvs_pkg::REG_RADIUS: m_radius = val & 16'hFFFF;
			uvs_pkg::REG_SLICES: m_slices = val & 11'h7FF;
			uvs_pkg::REG_STACKS: m_stacks = val & 11'h7FF;
			default: ;
		endcase
	endtask

	// called at a falling edge at which the sender has made no assignment
	task automatic drain;
		in_item.valid <= 1'b0;
		while (vertex_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 8) @(negedge clk);
	endtask

	task automatic set_config(input int unsigned r, input int unsigned s, input int unsigned t);
		drain();
		write_reg(uvs_pkg::REG_RADIUS, r);
		write_reg(uvs_pkg::REG_SLICES, s);
		write_reg(uvs_pkg::REG_STACKS, t);
	endtask

	// called at a falling edge; returns at the falling edge after the transfer
	// with valid still high
	task automatic send_point(input int unsigned ring, input int unsigned slice);
		vertex_t v;
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_item.valid <= 1'b0;
			@(negedge clk);
		end
		in_item.valid <= 1'b1;
		in_item.ring_index <= ring[uvs_pkg::CNT_W-1:0];
		in_item.slice_index <= slice[uvs_pkg::CNT_W-1:0];
		predict_vertex(ring & 11'h7FF, slice & 11'h7FF, v);
		do @(posedge clk); while (!in_item.ready);
		vertex_q = {vertex_q, v};
		@(negedge clk);
	endtask

	always @(negedge clk)
		out_item.ready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		vertex_t got, exp_v;
		if (arst_n && out_item.valid && out_item.ready) begin
			got = {out_item.pos_x, out_item.pos_y, out_item.pos_z, out_item.normal_x,
				out_item.normal_y, out_item.normal_z, out_item.tangent_x, out_item.tangent_y,
				out_item.tangent_z, out_item.tex_u, out_item.tex_v, out_item.index_error};
			if (vertex_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected vertex %h", got);
			end else begin
				exp_v = vertex_q.pop_front();
				if (got !== exp_v) begin
					errors++;
					if (errors <= 10)
						$display("vertex mismatch: exp %p act %p", exp_v, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_item.valid && in_item.ready) || (out_item.valid && out_item.ready)
				|| (vertex_q.size() == 0 && !in_item.valid))
			watchdog <= 0;
		else
			watchdog <= watchdog + 1;
		if (watchdog >= WD_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic test_directed;
		set_config(256, 16, 16);
		send_point(0, 0); send_point(0, 2047); send_point(16, 5); send_point(16, 2047);
		send_point(1, 0); send_point(8, 4); send_point(15, 16); send_point(8, 17);
		send_point(17, 0); send_point(2047, 2047); send_point(4, 12);
		set_config(65535, 3, 2);
		send_point(1, 0); send_point(1, 1); send_point(1, 2); send_point(1, 3);
		send_point(2, 0); send_point(1, 4);
		set_config(0, 1024, 1024);
		send_point(1, 1024); send_point(1023, 1023); send_point(512, 256);
		set_config(40000, 0, 0);
		send_point(1, 2); send_point(2, 3);
		set_config(300, 2047, 2047);
		send_point(1023, 1024); send_point(1024, 1); send_point(1025, 1);
	endtask

	task automatic test_random(input int n);
		int unsigned s_eff, t_eff, r;
		for (int i = 0; i < n; i++) begin
			if (i % 200 == 0) begin
				r = $urandom_range(3);
				set_config(r == 0 ? $urandom_range(65535) : (r == 1 ? 65535 : $urandom_range(512)),
					$urandom_range(9) == 0 ? $urandom_range(2047) : $urandom_range(3, 64),
					$urandom_range(9) == 0 ? $urandom_range(2047) : $urandom_range(2, 64));
			end
			s_eff = m_slices < 3 ? 3 : (m_slices > 1024 ? 1024 : m_slices);
			t_eff = m_stacks < 2 ? 2 : (m_stacks > 1024 ? 1024 : m_stacks);
			if ($urandom_range(9) == 0)
				send_point($urandom_range(2047), $urandom_range(2047));
			else
				send_point($urandom_range(t_eff), $urandom_range(s_eff));
		end
	endtask

	initial begin
		m_radius = uvs_pkg::RADIUS_RST;
		m_slices = uvs_pkg::SLICES_RST;
		m_stacks = uvs_pkg::STACKS_RST;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		send_point(8, 3);
		idle_pct = 0;  stall_pct = 0;  test_directed();
		idle_pct = 0;  stall_pct = 0;  test_random(400);
		idle_pct = 61; stall_pct = 0;  test_random(400);
		idle_pct = 0;  stall_pct = 61; test_random(400);
		idle_pct = 14; stall_pct = 14; test_random(350);
		idle_pct = 0;  stall_pct = 0;
		drain();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
